FILE: sv/clksync_pkg.sv
//------------------------------------------------------------------------------
// clksync_pkg
// Shared types and constants for the local to global clock sync block.
//------------------------------------------------------------------------------
`default_nettype none

package clksync_pkg;

   localparam int SCALE_FRAC_BITS_DEF    = 30;
   localparam int LOCAL_COUNTER_BITS_DEF = 32;

   localparam logic [31:0] WRAP_GUARD_RESET = 32'd1000000000;

   // sync status codes
   localparam logic [2:0] STAT_QUERY   = 3'd0;
   localparam logic [2:0] STAT_FIRST   = 3'd1;
   localparam logic [2:0] STAT_REPEAT  = 3'd2;
   localparam logic [2:0] STAT_REBASE  = 3'd3;
   localparam logic [2:0] STAT_RESCALE = 3'd4;

   typedef struct packed {
      logic        action;
      logic [31:0] local_us;
      logic [62:0] global_us;
   } req_word_type;

   typedef struct packed {
      logic signed [63:0] estimate_us;
      logic [2:0]         sync_status;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: sv/clksync_mul.sv
//------------------------------------------------------------------------------
// clksync_mul
// Bit-serial 32 x 64 multiplier, shifted right by the scale fraction and capped.
//------------------------------------------------------------------------------
`default_nettype none

module clksync_mul #(
   parameter int FRAC_BITS = clksync_pkg::SCALE_FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] scale,
   input  wire logic [63:0] multiplicand,
   output logic             done,
   output logic [62:0]      product
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] scale_ff, scale_in;
   logic [63:0] x_ff, x_in;
   logic [95:0] acc_ff, acc_in;
   logic [64:0] sum;
   logic [95:0] shifted;

   always_comb begin
      sum      = {1'b0, acc_ff[95:32]} + (scale_ff[0] ? {1'b0, x_ff} : 65'd0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      scale_in = scale_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         scale_in = scale;
         x_in     = multiplicand;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in   = {sum, acc_ff[31:1]};
         scale_in = scale_ff >> 1;
         cnt_in   = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      scale_ff <= scale_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
   end

   // saturate at the top of the signed range
   assign shifted = acc_ff >> FRAC_BITS;
   assign product = (|shifted[95:63]) ? '1 : shifted[62:0];
   assign done    = done_ff;

endmodule

`default_nettype wire

FILE: sv/clksync_div.sv
//------------------------------------------------------------------------------
// clksync_div
// Restoring radix-2 divider for the rate ratio, quotient saturated to 32 bits.
//------------------------------------------------------------------------------
`default_nettype none

module clksync_div #(
   parameter int FRAC_BITS = clksync_pkg::SCALE_FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [62:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [31:0]      quot
);

   localparam int DvdW = 63 + FRAC_BITS;
   localparam int CntW = $clog2(DvdW);
   localparam logic [CntW-1:0] LastCnt = CntW'(DvdW - 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [DvdW-1:0] dvd_ff, dvd_in;
   logic [63:0]     rem_ff, rem_in;
   logic [63:0]     den_ff, den_in;
   logic [31:0]     q_ff, q_in;
   logic            ovf_ff, ovf_in;
   logic [64:0]     r2;
   logic [64:0]     diff;
   logic            ge;

   always_comb begin
      r2      = {rem_ff, dvd_ff[DvdW-1]};
      diff    = r2 - {1'b0, den_ff};
      ge      = (r2 >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LastCnt;
         dvd_in  = {num, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = den;
         q_in    = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : r2[63:0];
         q_in   = {q_ff[30:0], ge};
         ovf_in = ovf_ff | q_ff[31];
         dvd_in = dvd_ff << 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign quot = ovf_ff ? '1 : q_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

FILE: sv/local_to_global_clock_sync.sv
//------------------------------------------------------------------------------
// local_to_global_clock_sync
// Maps a wrapping local microsecond counter onto global time.
//------------------------------------------------------------------------------
// A req word carries an action (query or sync), a raw local counter reading
// and, for a sync, a global timestamp. Every word gives one rsp word with the
// saturated global time estimate for its local reading and a sync status.
// A word is taken when req_valid is high and req_stall low; req_stall is high
// while a word is in work. The rsp word sits in an output register until the
// receiver drops rsp_stall, and the next req word may be taken meanwhile.
// Steps: a query or a non-rescaling sync is classified, then multiplied
// bit-serially, then its result and its rsp word are registered. The next
// req word can be taken once the rsp word is in its output register, so only
// one word is in work at a time. A rescaling sync also runs the restoring
// divider between the classify and multiply steps.
// Reset clears the learned map to unity scale and zero offset, drops the
// stored sample and the wrap count, and sets the wrap guard to 1e9 us.
// csr_wr_en writes the wrap guard; write it only while the block is idle.
//------------------------------------------------------------------------------
`default_nettype none

module local_to_global_clock_sync #(
   parameter int SCALE_FRAC_BITS    = clksync_pkg::SCALE_FRAC_BITS_DEF,
   parameter int LOCAL_COUNTER_BITS = clksync_pkg::LOCAL_COUNTER_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire clksync_pkg::req_word_type req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output clksync_pkg::rsp_word_type      rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [31:0]               csr_wr_data
);

   localparam logic [63:0] UnityWide  = 64'd1 << SCALE_FRAC_BITS;
   localparam logic [31:0] RateUnity  =
      (UnityWide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : UnityWide[31:0];
   localparam logic [63:0] LocalMask  = (64'd1 << LOCAL_COUNTER_BITS) - 64'd1;
   localparam logic [63:0] EstMax     = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLASS = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] guard_ff, guard_in;
   logic [31:0] rate_ff, rate_in;
   logic [63:0] offset_ff, offset_in;
   logic [63:0] prev_local_ff, prev_local_in;
   logic [62:0] prev_global_ff, prev_global_in;
   logic        have_ff, have_in;
   logic [31:0] prev_raw_ff, prev_raw_in;
   logic [31:0] wrap_ff, wrap_in;
   logic        sync_ff, sync_in;
   logic [63:0] local_ff, local_in;
   logic [62:0] glob_ff, glob_in;
   logic [2:0]  status_ff, status_in;
   logic [63:0] est_ff, est_in;
   logic        rsp_valid_ff, rsp_valid_in;
   clksync_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic        wrap_hit;
   logic [31:0] wrap_next;
   logic [63:0] local_next;
   logic        same;
   logic        back;
   logic        rescale;
   logic [62:0] div_num;
   logic [63:0] div_den;
   logic        div_start, div_done;
   logic [31:0] div_quot;
   logic        mul_start, mul_done;
   logic [31:0] mul_scale;
   logic [62:0] mul_product;
   logic [63:0] est_sum;

   // wrap extension of the raw counter
   always_comb begin
      wrap_hit   = (prev_raw_ff > guard_ff) &&
                   (req_data.local_us < (prev_raw_ff - guard_ff));
      wrap_next  = wrap_ff + {31'd0, wrap_hit};
      local_next = ({32'd0, wrap_next} << LOCAL_COUNTER_BITS) |
                   ({32'd0, req_data.local_us} & LocalMask);
   end

   // sample classification
   always_comb begin
      same    = (local_ff == prev_local_ff) || (glob_ff == prev_global_ff);
      back    = (prev_local_ff > local_ff) || (prev_global_ff > glob_ff);
      rescale = sync_ff && have_ff && !same && !back;
      div_num = glob_ff - prev_global_ff;
      div_den = local_ff - prev_local_ff;
   end

   assign div_start = (state_ff == S_CLASS) && rescale;
   assign mul_start = ((state_ff == S_CLASS) && !rescale) ||
                      ((state_ff == S_DIV) && div_done);
   assign mul_scale = (state_ff == S_DIV) ? div_quot : rate_ff;
   assign est_sum   = {1'b0, mul_product} + offset_ff;

   clksync_div #(
      .FRAC_BITS (SCALE_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   clksync_mul #(
      .FRAC_BITS (SCALE_FRAC_BITS)
   ) u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .scale        (mul_scale),
      .multiplicand (local_ff),
      .done         (mul_done),
      .product      (mul_product)
   );

   always_comb begin
      state_in       = state_ff;
      guard_in       = guard_ff;
      rate_in        = rate_ff;
      offset_in      = offset_ff;
      prev_local_in  = prev_local_ff;
      prev_global_in = prev_global_ff;
      have_in        = have_ff;
      prev_raw_in    = prev_raw_ff;
      wrap_in        = wrap_ff;
      sync_in        = sync_ff;
      local_in       = local_ff;
      glob_in        = glob_ff;
      status_in      = status_ff;
      est_in         = est_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (csr_wr_en) begin
         guard_in = csr_wr_data;
      end

      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               wrap_in     = wrap_next;
               prev_raw_in = req_data.local_us;
               local_in    = local_next;
               glob_in     = req_data.global_us;
               sync_in     = req_data.action;
               state_in    = S_CLASS;
            end
         end
         S_CLASS: begin
            if (!sync_ff) begin
               status_in = clksync_pkg::STAT_QUERY;
            end else if (!have_ff) begin
               status_in = clksync_pkg::STAT_FIRST;
            end else if (same) begin
               status_in = clksync_pkg::STAT_REPEAT;
            end else if (back) begin
               status_in = clksync_pkg::STAT_REBASE;
            end else begin
               status_in = clksync_pkg::STAT_RESCALE;
            end
            if (sync_ff && !(have_ff && same)) begin
               prev_local_in  = local_ff;
               prev_global_in = glob_ff;
               have_in        = 1'b1;
            end
            state_in = rescale ? S_DIV : S_MUL;
         end
         S_DIV: begin
            if (div_done) begin
               rate_in  = div_quot;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               if ((status_ff == clksync_pkg::STAT_REBASE) ||
                   (status_ff == clksync_pkg::STAT_RESCALE)) begin
                  offset_in = {1'b0, glob_ff} - {1'b0, mul_product};
                  est_in    = {1'b0, glob_ff};
               end else if (!offset_ff[63] && est_sum[63]) begin
                  est_in = EstMax;
               end else begin
                  est_in = est_sum;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.estimate_us = est_ff;
               rsp_data_in.sync_status = status_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         guard_ff       <= clksync_pkg::WRAP_GUARD_RESET;
         rate_ff        <= RateUnity;
         offset_ff      <= '0;
         prev_local_ff  <= '0;
         prev_global_ff <= '0;
         have_ff        <= 1'b0;
         prev_raw_ff    <= '0;
         wrap_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         guard_ff       <= guard_in;
         rate_ff        <= rate_in;
         offset_ff      <= offset_in;
         prev_local_ff  <= prev_local_in;
         prev_global_ff <= prev_global_in;
         have_ff        <= have_in;
         prev_raw_ff    <= prev_raw_in;
         wrap_ff        <= wrap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      sync_ff     <= sync_in;
      local_ff    <= local_in;
      glob_ff     <= glob_in;
      status_ff   <= status_in;
      est_ff      <= est_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: test/local_to_global_clock_sync_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// local_to_global_clock_sync_tb
// Self-checking bench for the local to global clock sync block.
//------------------------------------------------------------------------------
// Words are driven from a queue: a short directed set first, then eight
// phases of drifting clock samples. Each phase uses its own wrap guard and one
// of four patterns of sender and receiver idling. An internal model of the linear time map
// predicts every rsp word, and the monitor checks each one in order.
//------------------------------------------------------------------------------

module local_to_global_clock_sync_tb;

   localparam int FRAC        = clksync_pkg::SCALE_FRAC_BITS_DEF;
   localparam int STALL_LIMIT = 3000;
   localparam logic signed [63:0] EST_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   clksync_pkg::req_word_type req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   clksync_pkg::rsp_word_type rsp_data;
   logic                      csr_wr_en   = 1'b0;
   logic [31:0]               csr_wr_data = '0;

   clksync_pkg::req_word_type queued_words[$];
   clksync_pkg::rsp_word_type pending_estimates[$];
   clksync_pkg::rsp_word_type want_word;
   logic         req_taken = 1'b0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           long_hold_left = 0;
   int           quiet_cycles = 0;
   int           mismatches = 0;

   // time map state
   logic [31:0]        map_guard;
   logic [31:0]        map_scale;
   logic signed [63:0] map_offset;
   logic [63:0]        last_local_ext;
   logic [62:0]        last_global;
   logic               have_fix;
   logic [31:0]        last_raw;
   logic [31:0]        wrap_total;

   // drifting clock source for the random words
   logic [63:0] gen_local;
   logic [62:0] gen_global;
   logic [31:0] gen_sync_local;
   logic [62:0] gen_sync_global;
   int          drift_num;

   local_to_global_clock_sync i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] scale_local(logic [31:0] s, logic [63:0] x);
      logic [95:0] prod;
      prod = ({64'd0, s} * {32'd0, x}) >> FRAC;
      if (prod[95:63] != '0) return 64'h7FFF_FFFF_FFFF_FFFF;
      return prod[63:0];
   endfunction

   function automatic logic [31:0] rate_from_deltas(logic [62:0] dg, logic [63:0] dl);
      logic [95:0] quo;
      quo = ({33'd0, dg} << FRAC) / {32'd0, dl};
      if (quo[95:32] != '0) return 32'hFFFF_FFFF;
      return quo[31:0];
   endfunction

   task automatic clear_clock_map();
      map_guard      = clksync_pkg::WRAP_GUARD_RESET;
      map_scale      = 32'd1 << FRAC;
      map_offset     = '0;
      last_local_ext = '0;
      last_global    = '0;
      have_fix       = 1'b0;
      last_raw       = '0;
      wrap_total     = '0;
   endtask

   task automatic predict_word(input clksync_pkg::req_word_type w);
      logic [63:0]               lext;
      logic [2:0]                stat;
      logic signed [63:0]        base;
      clksync_pkg::rsp_word_type r;
      if (last_raw > map_guard && w.local_us < last_raw - map_guard)
         wrap_total = wrap_total + 32'd1;
      last_raw = w.local_us;
      lext = {wrap_total, w.local_us};
      stat = clksync_pkg::STAT_QUERY;
      if (w.action) begin
         if (!have_fix) begin
            stat = clksync_pkg::STAT_FIRST;
         end else if (lext == last_local_ext || w.global_us == last_global) begin
            stat = clksync_pkg::STAT_REPEAT;
         end else if (last_local_ext > lext || last_global > w.global_us) begin
            map_offset = $signed({1'b0, w.global_us}) - $signed(scale_local(map_scale, lext));
            stat = clksync_pkg::STAT_REBASE;
         end else begin
            map_scale  = rate_from_deltas(w.global_us - last_global, lext - last_local_ext);
            map_offset = $signed({1'b0, w.global_us}) - $signed(scale_local(map_scale, lext));
            stat = clksync_pkg::STAT_RESCALE;
         end
         if (stat != clksync_pkg::STAT_REPEAT) begin
            last_local_ext = lext;
            last_global    = w.global_us;
            have_fix       = 1'b1;
         end
      end
      base = $signed(scale_local(map_scale, lext));
      if (map_offset > 0 && base > EST_MAX - map_offset) r.estimate_us = EST_MAX;
      else r.estimate_us = base + map_offset;
      r.sync_status = stat;
      pending_estimates.push_back(r);
   endtask

   task automatic queue_word(input logic act, input logic [31:0] lus, input logic [62:0] gus);
      clksync_pkg::req_word_type w;
      w.action    = act;
      w.local_us  = lus;
      w.global_us = gus;
      queued_words.push_back(w);
   endtask

   task automatic queue_drift_words(input int count);
      clksync_pkg::req_word_type w;
      int                        kind;
      logic [63:0]               step;
      repeat (count) begin
         kind = $urandom_range(99);
         w.action = 1'($urandom_range(1));
         if (kind < 72) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: step = 64'($urandom_range(100000, 1));
               5, 6, 7:       step = 64'($urandom_range(32'h1000_0000, 1));
               8:             step = 64'($urandom_range(32'hFFFF_FFFF, 32'h4000_0000));
               default:       step = '0;
            endcase
            gen_local  = gen_local + step;
            gen_global = gen_global + 63'((step * 64'(drift_num)) >> 10) +
                         63'($urandom_range(40));
            w.local_us  = gen_local[31:0];
            w.global_us = gen_global;
         end else if (kind < 80) begin
            // time going backwards on one side or both
            w.action    = 1'b1;
            w.local_us  = gen_local[31:0] - $urandom_range(5000);
            w.global_us = gen_global - 63'($urandom_range(5000));
         end else if (kind < 90) begin
            w.action = 1'b1;
            if ($urandom_range(1)) begin
               w.local_us  = gen_sync_local;
               w.global_us = gen_global + 63'($urandom_range(1000));
            end else begin
               w.local_us  = gen_local[31:0] + $urandom_range(1000);
               w.global_us = gen_sync_global;
            end
         end else begin
            w.local_us  = $urandom;
            w.global_us = 63'({$urandom, $urandom});
         end
         if (w.action) begin
            gen_sync_local  = w.local_us;
            gen_sync_global = w.global_us;
         end
         queued_words.push_back(w);
      end
   endtask

   task automatic wait_idle();
      while (queued_words.size() != 0 || req_valid || pending_estimates.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_guard(input logic [31:0] v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= queued_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_stall      <= 1'b1;
      end else begin
         rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
      end
   end

   // prediction and checking
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) predict_word(req_data);
      if (!reset && csr_wr_en) map_guard = csr_wr_data;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp word: estimate_us=%0d sync_status=%0d",
                        rsp_data.estimate_us, rsp_data.sync_status);
         end else begin
            want_word = pending_estimates.pop_front();
            if (rsp_data.estimate_us !== want_word.estimate_us ||
                rsp_data.sync_status !== want_word.sync_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: estimate_us exp %0d got %0d, sync_status exp %0d got %0d",
                           want_word.estimate_us, rsp_data.estimate_us,
                           want_word.sync_status, rsp_data.sync_status);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] guard;
      clear_clock_map();
      gen_local       = '0;
      gen_global      = 63'd1000;
      gen_sync_local  = '0;
      gen_sync_global = '0;
      drift_num       = 1024;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words under the reset wrap guard
      queue_word(1'b0, 32'h0000_0000, 63'd0);
      queue_word(1'b0, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
      queue_word(1'b0, 32'h0000_0000, 63'd0);
      queue_word(1'b1, 32'd1000, 63'd5000);
      queue_word(1'b1, 32'd1000, 63'd6000);
      queue_word(1'b1, 32'd2000, 63'd5000);
      queue_word(1'b1, 32'd3000, 63'd9000);
      queue_word(1'b1, 32'd2500, 63'd10000);
      queue_word(1'b1, 32'd4000, 63'd9500);
      queue_word(1'b1, 32'd5000, 63'h7FFF_FFFF_FFFF_FFFF);
      queue_word(1'b0, 32'hFFFF_FFF0, 63'd0);
      queue_word(1'b1, 32'd6000, 63'd0);
      queue_word(1'b0, 32'd100, 63'h7FFF_FFFF_FFFF_FFFF);
      queue_word(1'b1, 32'd7000, 63'd1);
      queue_word(1'b1, 32'd8000, 63'd1);
      queue_word(1'b0, 32'd0, 63'd0);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       guard = 32'd0;
            1:       guard = 32'hFFFF_FFFF;
            2:       guard = clksync_pkg::WRAP_GUARD_RESET;
            3:       guard = $urandom;
            4:       guard = $urandom_range(2000000);
            5:       guard = 32'h8000_0000;
            6:       guard = 32'd1;
            default: guard = $urandom_range(32'hFFFF_FFFF, 32'h2000_0000);
         endcase
         write_guard(guard);
         case (p % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 67; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         drift_num = $urandom_range(1300, 700);
         queue_drift_words(240);
         if (p == 0) begin
            // receiver holds off while words keep coming
            @(posedge clock);
            long_hold_left = 300;
         end
         wait_idle();
      end

      repeat (150) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
